>>> rtl/miller_rabin_round_tester_unit_defines.svh
// assertion macros used by the checker file
`ifndef MILLER_RABIN_ROUND_TESTER_UNIT_DEFINES_SVH
`define MILLER_RABIN_ROUND_TESTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define MRRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define MRRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mrrt_pkg.sv
// shared constants and types of the miller-rabin round tester
package mrrt_pkg;

  // fixed port width of the number fields
  localparam int unsigned PORT_W = 32;
  // width of the arithmetic, only the low NUM_WIDTH bits of each field are used
  localparam int unsigned NUM_WIDTH = 32;
  // bit index and squaring count width
  localparam int unsigned IDX_W = $clog2(NUM_WIDTH);
  // candidates up to this value always pass
  localparam logic [NUM_WIDTH-1:0] SMALL_MAX = NUM_WIDTH'(3);
  localparam logic [NUM_WIDTH-1:0] NUM_ONE   = NUM_WIDTH'(1);

  typedef logic [NUM_WIDTH-1:0] num_t;

  // request to the modular multiplier
  typedef struct packed {
    logic start;
    num_t x;
    num_t y;
  } mul_req_t;

  // result of the modular multiplier
  typedef struct packed {
    logic done;
    num_t res;
  } mul_rsp_t;

  // sequencer status toward the handshake logic
  typedef struct packed {
    logic idle;
    logic done;
    logic pass;
  } ctrl_stat_t;

endpackage

>>> rtl/miller_rabin_round_tester_unit.sv
// top level of the miller-rabin round tester
//
// One Miller-Rabin round per input transfer: candidate_i (number under
// test), witness_i and last_witness_i. Each input transfer yields exactly one
// output transfer with round_pass_o and verdict_o, the AND of all rounds since
// the last round marked by last_witness_i; the running AND returns to pass
// after that marked round.
// Candidates up to 3 and even candidates go straight to the done state and
// use no multiplier. Odd ones use a bit-serial modular multiplier:
// one reduction of the witness, 32 squarings, one product per set bit of d
// and up to k-1 squarings, at most 64 products. Splitting n-1 into d * 2^k
// comes before them, and each squaring of the final loop is followed by a
// check against n-1; one shared multiplier does every product in turn.
// One item is in work at a time; in_ready_o is high only while the sequencer
// is idle. Results sit in an output register, so a new item can be taken
// while the previous result waits; a stalled receiver blocks the sequencer
// only once it has a second result ready.
// Reset clears the running verdict to pass and empties the output register.
module miller_rabin_round_tester_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mrrt_pkg::PORT_W-1:0] candidate_i,
  input  logic [mrrt_pkg::PORT_W-1:0] witness_i,
  input  logic                        last_witness_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        round_pass_o,
  output logic                        verdict_o
);

  localparam int unsigned NW = mrrt_pkg::NUM_WIDTH;

  mrrt_pkg::mul_req_t   mul_req;
  mrrt_pkg::mul_rsp_t   mul_rsp;
  mrrt_pkg::num_t       mod_n;
  mrrt_pkg::ctrl_stat_t stat;

  logic in_xfer;
  logic ack;
  logic last_q;
  logic run_q;
  logic out_valid_q;
  logic pass_out_q;
  logic verdict_out_q;
  logic verdict_new;

  assign in_ready_o = stat.idle;
  assign in_xfer    = in_valid_i & stat.idle;
  assign ack        = stat.done & (~out_valid_q | out_ready_i);
  assign verdict_new = run_q & stat.pass;

  mrrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .cand_i  (candidate_i[NW-1:0]),
    .wit_i   (witness_i[NW-1:0]),
    .ack_i   (ack),
    .rsp_i   (mul_rsp),
    .req_o   (mul_req),
    .n_o     (mod_n),
    .stat_o  (stat)
  );

  mrrt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .n_i    (mod_n),
    .rsp_o  (mul_rsp)
  );

  // last-witness mark travels with the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      last_q <= last_witness_i;
    end
  end

  // running verdict and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (ack) begin
        out_valid_q <= 1'b1;
        run_q       <= last_q | verdict_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      pass_out_q    <= stat.pass;
      verdict_out_q <= verdict_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign round_pass_o = pass_out_q;
  assign verdict_o    = verdict_out_q;

endmodule

>>> rtl/mrrt_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module mrrt_modmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrrt_pkg::mul_req_t req_i,
  input  mrrt_pkg::num_t     n_i,
  output mrrt_pkg::mul_rsp_t rsp_o
);

  localparam int unsigned NW  = mrrt_pkg::NUM_WIDTH;
  localparam int unsigned TW  = NW + 2;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [mrrt_pkg::IDX_W-1:0] cnt_q, cnt_d;
  mrrt_pkg::num_t            x_q, x_d;
  mrrt_pkg::num_t            y_q, y_d;
  mrrt_pkg::num_t            r_q, r_d;

  logic [TW-1:0] t_sum;
  logic [TW-1:0] n_one;
  logic [TW-1:0] n_two;
  logic [TW-1:0] t_red;

  // partial sum 2r + bit * x, always below three times the modulus
  assign t_sum = {1'b0, r_q, 1'b0} + {2'b00, (y_q[NW-1] ? x_q : '0)};
  assign n_one = {2'b00, n_i};
  assign n_two = {1'b0, n_i, 1'b0};

  // reduce with a single pick among three parallel candidates
  always_comb begin
    if (t_sum >= n_two) begin
      t_red = t_sum - n_two;
    end else if (t_sum >= n_one) begin
      t_red = t_sum - n_one;
    end else begin
      t_red = t_sum;
    end
  end

  // operand capture and bit stepping
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = mrrt_pkg::IDX_W'(NW - 1);
      x_d    = req_i.x;
      y_d    = req_i.y;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = t_red[NW-1:0];
      y_d   = {y_q[NW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    x_q   <= x_d;
    y_q   <= y_d;
    r_q   <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q;

endmodule

>>> rtl/mrrt_ctrl.sv
// round sequencer: factoring, square-and-multiply and the final squaring loop
module mrrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mrrt_pkg::num_t        cand_i,
  input  mrrt_pkg::num_t        wit_i,
  input  logic                  ack_i,
  input  mrrt_pkg::mul_rsp_t    rsp_i,
  output mrrt_pkg::mul_req_t    req_o,
  output mrrt_pkg::num_t        n_o,
  output mrrt_pkg::ctrl_stat_t  stat_o
);

  localparam int unsigned NW = mrrt_pkg::NUM_WIDTH;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FACTOR = 8'b0000_0010,
    ST_REDUCE = 8'b0000_0100,
    ST_SQR    = 8'b0000_1000,
    ST_MUL    = 8'b0001_0000,
    ST_CHK    = 8'b0010_0000,
    ST_LOOP   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e                     state_q, state_d;
  logic                       pass_q, pass_d;
  mrrt_pkg::mul_req_t         req_q, req_d;
  mrrt_pkg::num_t             n_q, n_d;
  mrrt_pkg::num_t             a_q, a_d;
  mrrt_pkg::num_t             base_q, base_d;
  mrrt_pkg::num_t             r_q, r_d;
  mrrt_pkg::num_t             exp_q, exp_d;
  logic [mrrt_pkg::IDX_W-1:0] k_q, k_d;
  logic [mrrt_pkg::IDX_W-1:0] bit_q, bit_d;

  logic           step_bit;
  mrrt_pkg::num_t step_val;
  mrrt_pkg::num_t n_m1;

  assign n_m1 = n_q - mrrt_pkg::NUM_ONE;

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    req_d     = req_q;
    req_d.start = 1'b0;
    n_d       = n_q;
    a_d       = a_q;
    base_d    = base_q;
    r_d       = r_q;
    exp_d     = exp_q;
    k_d       = k_q;
    bit_d     = bit_q;
    step_bit  = 1'b0;
    step_val  = rsp_i.res;

    case (state_q)
      // take the item and sort out the trivial candidates
      ST_IDLE: begin
        if (start_i) begin
          n_d   = cand_i;
          a_d   = wit_i;
          exp_d = cand_i - mrrt_pkg::NUM_ONE;
          k_d   = '0;
          if (cand_i <= mrrt_pkg::SMALL_MAX) begin
            pass_d  = 1'b1;
            state_d = ST_DONE;
          end else if (!cand_i[0]) begin
            pass_d  = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_FACTOR;
          end
        end
      end
      // strip trailing zeros of n-1, one per cycle
      ST_FACTOR: begin
        if (!exp_q[0]) begin
          exp_d = {1'b0, exp_q[NW-1:1]};
          k_d   = k_q + 1'b1;
        end else begin
          req_d.start = 1'b1;
          req_d.x     = mrrt_pkg::NUM_ONE;
          req_d.y     = a_q;
          state_d     = ST_REDUCE;
        end
      end
      // witness mod n, then first squaring of 1
      ST_REDUCE: begin
        if (rsp_i.done) begin
          base_d      = rsp_i.res;
          bit_d       = mrrt_pkg::IDX_W'(NW - 1);
          req_d.start = 1'b1;
          req_d.x     = mrrt_pkg::NUM_ONE;
          req_d.y     = mrrt_pkg::NUM_ONE;
          state_d     = ST_SQR;
        end
      end
      ST_SQR: begin
        if (rsp_i.done) begin
          r_d = rsp_i.res;
          if (exp_q[NW-1]) begin
            req_d.start = 1'b1;
            req_d.x     = rsp_i.res;
            req_d.y     = base_q;
            state_d     = ST_MUL;
          end else begin
            step_bit = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (rsp_i.done) begin
          r_d      = rsp_i.res;
          step_bit = 1'b1;
        end
      end
      // look for n-1 with the squarings that are left
      ST_CHK: begin
        if (r_q == n_m1) begin
          pass_d  = 1'b1;
          state_d = ST_DONE;
        end else if (k_q == mrrt_pkg::IDX_W'(1)) begin
          pass_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          k_d         = k_q - 1'b1;
          req_d.start = 1'b1;
          req_d.x     = r_q;
          req_d.y     = r_q;
          state_d     = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (rsp_i.done) begin
          r_d     = rsp_i.res;
          state_d = ST_CHK;
        end
      end
      // hold the result until the output side takes it
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // advance to the next exponent bit or finish the power
    if (step_bit) begin
      if (bit_q == '0) begin
        if (step_val == mrrt_pkg::NUM_ONE) begin
          pass_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHK;
        end
      end else begin
        bit_d       = bit_q - 1'b1;
        exp_d       = {exp_q[NW-2:0], 1'b0};
        req_d.start = 1'b1;
        req_d.x     = step_val;
        req_d.y     = step_val;
        state_d     = ST_SQR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    n_q    <= n_d;
    a_q    <= a_d;
    base_q <= base_d;
    r_q    <= r_d;
    exp_q  <= exp_d;
    k_q    <= k_d;
    bit_q  <= bit_d;
  end

  assign req_o       = req_q;
  assign n_o         = n_q;
  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign stat_o.pass = pass_q;

endmodule

>>> rtl/mrrt_checker.sv
// port-level checks of the round tester and their bind
`include "miller_rabin_round_tester_unit_defines.svh"

module mrrt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [mrrt_pkg::PORT_W-1:0] candidate_i,
  input logic [mrrt_pkg::PORT_W-1:0] witness_i,
  input logic                        last_witness_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        round_pass_o,
  input logic                        verdict_o
);

  // a stalled result holds
  `MRRT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(round_pass_o) && $stable(verdict_o), "stalled result changed")

  // the running verdict never passes a failed round
  `MRRT_ASSERT_NOW(a_verdict_and, out_valid_o && verdict_o, round_pass_o, "verdict set on a failed round")

  // one item at a time: the engine is busy right after an input transfer
  `MRRT_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // a result moves out only as the engine frees up
  `MRRT_ASSERT_NOW(a_idle_on_result, $rose(out_valid_o), in_ready_o, "result without idle engine")

  // a waiting input keeps its payload
  `MRRT_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(candidate_i) && $stable(witness_i) && $stable(last_witness_i), "waiting input changed")

endmodule

bind miller_rabin_round_tester_unit mrrt_checker u_mrrt_checker (.*);

>>> test/tb_miller_rabin_round_tester_unit.sv
// testbench for the miller-rabin round tester: directed and random rounds against a predictor
module tb_miller_rabin_round_tester_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected output transfer, with the round that caused it for diagnostics
  typedef struct packed {
    mrrt_pkg::num_t cand;
    mrrt_pkg::num_t wit;
    logic round_pass;
    logic verdict;
  } round_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [mrrt_pkg::PORT_W-1:0] candidate_i;
  logic [mrrt_pkg::PORT_W-1:0] witness_i;
  logic                        last_witness_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic                        round_pass_o;
  logic                        verdict_o;

  round_result_t pending_results[$];
  round_result_t want;
  logic          running_and;
  bit            no_gaps;
  int unsigned   mismatch_count;

  miller_rabin_round_tester_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .candidate_i    (candidate_i),
    .witness_i      (witness_i),
    .last_witness_i (last_witness_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .round_pass_o   (round_pass_o),
    .verdict_o      (verdict_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well past the slowest correct run
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // (x * y) mod m on a full-width product
  function automatic mrrt_pkg::num_t mul_mod(mrrt_pkg::num_t x, mrrt_pkg::num_t y,
                                             mrrt_pkg::num_t m);
    logic [2*mrrt_pkg::NUM_WIDTH-1:0] prod;
    prod = {{mrrt_pkg::NUM_WIDTH{1'b0}}, x} * {{mrrt_pkg::NUM_WIDTH{1'b0}}, y};
    return mrrt_pkg::num_t'(prod % {{mrrt_pkg::NUM_WIDTH{1'b0}}, m});
  endfunction

  // one miller-rabin round: 1 if witness a finds no proof that n is composite
  function automatic logic mr_round(mrrt_pkg::num_t n, mrrt_pkg::num_t a);
    mrrt_pkg::num_t d;
    mrrt_pkg::num_t x;
    mrrt_pkg::num_t base;
    int unsigned    k;
    if (n <= mrrt_pkg::SMALL_MAX) return 1'b1;
    if (!n[0]) return 1'b0;
    // split n-1 into d * 2^k
    d = n - mrrt_pkg::NUM_ONE;
    k = 0;
    while (!d[0]) begin
      d = d >> 1;
      k++;
    end
    // left-to-right square-and-multiply over every exponent bit
    base = a % n;
    x = mrrt_pkg::NUM_ONE;
    for (int b = mrrt_pkg::NUM_WIDTH - 1; b >= 0; b--) begin
      x = mul_mod(x, x, n);
      if (d[b]) x = mul_mod(x, base, n);
    end
    if (x == mrrt_pkg::NUM_ONE) return 1'b1;
    // squaring chain looking for n-1
    for (int unsigned i = 0; i + 1 < k; i++) begin
      if (x == n - mrrt_pkg::NUM_ONE) break;
      x = mul_mod(x, x, n);
    end
    return x == n - mrrt_pkg::NUM_ONE;
  endfunction

  // drive one round and record the expected result once it is taken
  task automatic send_round(mrrt_pkg::num_t cand, mrrt_pkg::num_t wit, logic last);
    int unsigned   gap;
    round_result_t exp_item;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    candidate_i    = cand;
    witness_i      = wit;
    last_witness_i = last;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    exp_item.cand       = cand;
    exp_item.wit        = wit;
    exp_item.round_pass = mr_round(cand, wit);
    running_and         = running_and & exp_item.round_pass;
    exp_item.verdict    = running_and;
    if (last) running_and = 1'b1;
    pending_results = {pending_results, exp_item};
  endtask

  // hold the sender off until every expected result has come back
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // candidates 0 to 3 pass whatever the witness
  task automatic test_small_candidates();
    send_round(32'd0, 32'd0, 1'b0);
    send_round(32'd1, 32'd5, 1'b0);
    send_round(32'd2, 32'hFFFF_FFFF, 1'b0);
    send_round(32'd3, 32'd3, 1'b1);
  endtask

  // even candidates above 3 fail, the mark clears the running and
  task automatic test_even_candidates();
    send_round(32'd4, 32'd2, 1'b0);
    send_round(32'hFFFF_FFFE, 32'h0001_2345, 1'b1);
  endtask

  // witnesses 0, 1, n-1 and at and beyond the candidate, reduced mod n first
  task automatic test_witness_edges();
    send_round(32'd4294967291, 32'd0, 1'b0);
    send_round(32'd4294967291, 32'd4294967291, 1'b1);
    send_round(32'd4294967291, 32'd1, 1'b0);
    send_round(32'd4294967291, 32'd4294967290, 1'b0);
    send_round(32'd4294967291, 32'd4294967292, 1'b0);
    send_round(32'd4294967291, 32'hFFFF_FFFF, 1'b1);
  endtask

  // composites that fool some bases, and a carmichael number
  task automatic test_strong_pseudoprimes();
    send_round(32'd2047, 32'd2, 1'b1);
    send_round(32'd561, 32'd2, 1'b1);
    send_round(32'd3215031751, 32'd2, 1'b0);
    send_round(32'd3215031751, 32'd3, 1'b0);
    send_round(32'd3215031751, 32'd5, 1'b0);
    send_round(32'd3215031751, 32'd7, 1'b0);
    send_round(32'd3215031751, 32'd11, 1'b1);
  endtask

  // long squaring chains, all-ones candidate, candidate change without a mark
  task automatic test_long_chains();
    send_round(32'h8000_0001, 32'd2, 1'b1);
    send_round(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
    send_round(32'd3221225473, 32'd5, 1'b0);
    send_round(32'd65537, 32'd3, 1'b1);
    send_round(32'd97, 32'd5, 1'b0);
    send_round(32'd91, 32'd2, 1'b1);
  endtask

  // random candidates: mostly full witness sets, some noise
  task automatic test_random_rounds(int unsigned num_items);
    int unsigned    sent;
    int unsigned    kind;
    int unsigned    rounds;
    mrrt_pkg::num_t cand;
    mrrt_pkg::num_t wit;
    sent = 0;
    while (sent < num_items) begin
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // well-formed candidate with witnesses in 2..n-2
        case ($urandom_range(0, 9))
          0: cand = 32'd4294967291;
          1: cand = 32'd2147483647;
          2: cand = 32'd1000000007;
          3: cand = 32'd998244353;
          4: cand = 32'd3221225473;
          5: cand = 32'd3215031751;
          6: cand = mrrt_pkg::num_t'($urandom_range(5, 65535)) | mrrt_pkg::NUM_ONE;
          default: cand = mrrt_pkg::num_t'($urandom) | mrrt_pkg::NUM_ONE;
        endcase
        if (cand < 32'd5) cand = 32'd5;
        rounds = $urandom_range(1, 4);
        for (int unsigned r = 0; r < rounds; r++) begin
          wit = mrrt_pkg::num_t'($urandom % (cand - 32'd3)) + 32'd2;
          send_round(cand, wit, r == rounds - 1);
          sent++;
        end
      end else if (kind <= 8) begin
        // raw noise across every bit of every field
        send_round(mrrt_pkg::num_t'($urandom), mrrt_pkg::num_t'($urandom),
                   1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // tiny or even candidates
        cand = ($urandom_range(0, 1) == 1) ? mrrt_pkg::num_t'($urandom_range(0, 3))
                                           : (mrrt_pkg::num_t'($urandom) & ~mrrt_pkg::NUM_ONE);
        send_round(cand, mrrt_pkg::num_t'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // sender waits for a full drain, then sends two rounds, the second one marked
  task automatic test_drain_pause();
    wait_all_results();
    send_round(32'd1000000007, 32'd2, 1'b0);
    send_round(32'd1000000007, 32'd1000000005, 1'b1);
  endtask

  // receiver: random stall per result, with stretches of none
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      forever begin
        @(posedge clk_i);
        if (out_valid_o) break;
      end
    end
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output transfer: round_pass=%0b verdict=%0b",
                   round_pass_o, verdict_o);
      end else begin
        want = pending_results.pop_front();
        if (round_pass_o !== want.round_pass || verdict_o !== want.verdict) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch n=%0d a=%0d: round_pass exp %0b got %0b, verdict exp %0b got %0b",
                     want.cand, want.wit, want.round_pass, round_pass_o,
                     want.verdict, verdict_o);
        end
      end
    end
  end

  // reset, test sequence, drain and verdict
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    candidate_i    = '0;
    witness_i      = '0;
    last_witness_i = 1'b0;
    running_and    = 1'b1;
    no_gaps        = 1'b0;
    mismatch_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_small_candidates();
    test_even_candidates();
    test_witness_edges();
    test_strong_pseudoprimes();
    test_long_chains();
    test_random_rounds(55);
    test_drain_pause();
    test_random_rounds(55);

    wait_all_results();
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
